// ===== rtl/pwl_pkg.sv =====
`timescale 1ns / 1ps

package pwl_pkg;

    localparam int LIST_DEPTH    = 16;
    localparam int ID_BITS       = 8;
    localparam int PRIORITY_BITS = 16;
    localparam int CNT_BITS      = $clog2(LIST_DEPTH + 1);

    localparam int OP_W  = 2;
    localparam int IDF_W = 8;
    localparam int PRF_W = 16;
    localparam int OCC_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } pwl_op_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDF_W-1:0] requester_id;
        logic             persistent;
        logic [PRF_W-1:0] priority_req;
    } pwl_in_t;

    typedef struct packed {
        logic             found;
        logic             overflow;
        logic [OCC_W-1:0] occupancy;
    } pwl_out_t;

    typedef struct packed {
        logic                     valid;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        logic                     pers;
    } pwl_entry_t;

    typedef struct packed {
        logic                     ins_en;
        logic                     rem_en;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        logic                     pers;
    } pwl_cmd_t;

    localparam pwl_entry_t ENTRY_EMPTY = '0;

endpackage

// ===== rtl/priority_wait_list_top.sv =====
`timescale 1ns / 1ps
// Sorted wait list built as a chain of LIST_DEPTH cells, one entry per cell.
// The result is registered and presented in the cycle after the input transfer.
// Throughput: one operation per cycle while the output is not stalled; every cell compares and shifts at once.
// Reset (rst_n, async, active low): list empty, no result pending.
// Every cell clears along with the occupancy counter; the output payload holds.

module priority_wait_list_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwl_pkg::pwl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pwl_pkg::pwl_out_t out_data
);
    import pwl_pkg::*;

    pwl_entry_t          cell_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_after;
    logic [LIST_DEPTH-1:0] cell_hit;

    pwl_cmd_t            cmd;
    logic                take;
    logic                full;
    logic                is_ins;
    logic                is_match;
    logic                chain_found;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                out_valid_reg;
    pwl_out_t            out_data_reg;
    pwl_out_t            out_data_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign full        = (count_reg == CNT_BITS'(LIST_DEPTH));
    assign chain_found = cell_hit[LIST_DEPTH-1];

    always_comb
    begin
        is_ins   = 1'b0;
        is_match = 1'b0;
        cmd.rem_en = 1'b0;
        unique case (in_data.operation)
            OP_INSERT:
            begin
                is_ins = 1'b1;
            end
            OP_REMOVE:
            begin
                is_match   = 1'b1;
                cmd.rem_en = take;
            end
            OP_QUERY:
            begin
                is_match = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
        cmd.ins_en = take && is_ins && !full;
        cmd.id     = in_data.requester_id[ID_BITS-1:0];
        cmd.pri    = in_data.priority_req[PRIORITY_BITS-1:0];
        cmd.pers   = in_data.persistent;
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        pwl_entry_t left_e;
        pwl_entry_t right_e;
        logic       left_a;
        logic       left_h;

        if (i == 0)
        begin : g_head
            assign left_e = ENTRY_EMPTY;
            assign left_a = 1'b0;
            assign left_h = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_a = cell_after[i-1];
            assign left_h = cell_hit[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_tail
            assign right_e = ENTRY_EMPTY;
        end
        else
        begin : g_next
            assign right_e = cell_entry[i+1];
        end

        pwl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_after  (left_a),
            .left_hit    (left_h),
            .entry       (cell_entry[i]),
            .after       (cell_after[i]),
            .hit         (cell_hit[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rem_en && chain_found)
        begin
            count_next = count_reg - 1'b1;
        end
        out_data_next.found     = is_match && chain_found;
        out_data_next.overflow  = is_ins && full;
        out_data_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/pwl_cell.sv =====
`timescale 1ns / 1ps

module pwl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pwl_pkg::pwl_cmd_t   cmd,
    input  pwl_pkg::pwl_entry_t left_entry,
    input  pwl_pkg::pwl_entry_t right_entry,
    input  logic                left_after,
    input  logic                left_hit,
    output pwl_pkg::pwl_entry_t entry,
    output logic                after,
    output logic                hit
);
    import pwl_pkg::*;

    pwl_entry_t entry_reg;
    pwl_entry_t entry_next;
    logic       load;

    // after: new entry goes at or before this slot
    assign after = !entry_reg.valid || (entry_reg.pri > cmd.pri);
    assign hit   = left_hit || (entry_reg.valid && entry_reg.id == cmd.id
                                && entry_reg.pers == cmd.pers);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        load       = 1'b0;
        if (cmd.ins_en && after)
        begin
            load = 1'b1;
            if (left_after)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.valid = 1'b1;
                entry_next.id    = cmd.id;
                entry_next.pri   = cmd.pri;
                entry_next.pers  = cmd.pers;
            end
        end
        else if (cmd.rem_en && hit)
        begin
            load       = 1'b1;
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_EMPTY;
        end
        else if (load)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule
